FILE: rtl/sec_pkg.sv
// Shared types, register codes and arithmetic helpers for the sensor ensemble combiner.
// Used by every module in rtl/; depends on nothing else.
package sec_pkg;

  localparam int MAX_CHILDREN      = 4;
  localparam int DEF_CHILD_COUNT   = 4;
  localparam int CFG_INDEX_W       = 3;
  localparam int CFG_DATA_W        = 64;

  // Register indexes on the configuration port.
  localparam logic [CFG_INDEX_W-1:0] CFG_MODE    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_CHILD_A = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_CHILD_D = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_OUTER   = 3'd5;

  // Reduction codes; codes above MODE_PROD yield a zero raw result.
  localparam logic [2:0] MODE_MIN  = 3'd0;
  localparam logic [2:0] MODE_MAX  = 3'd1;
  localparam logic [2:0] MODE_AVG  = 3'd2;
  localparam logic [2:0] MODE_SUM  = 3'd3;
  localparam logic [2:0] MODE_PROD = 3'd4;
  localparam logic [2:0] MODE_RESET = MODE_SUM;

  typedef logic [63:0] coeff_t;
  localparam coeff_t COEFF_RESET = 64'h7FFF_8000_0000_0100;

  localparam logic signed [31:0] ACC_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] ACC_MIN = -32'sh7FFF_FFFF - 32'sd1;
  localparam logic signed [31:0] ACC_ONE = 32'sd256;

  function automatic logic signed [15:0] c_scale(input coeff_t c);
    return c[15:0];
  endfunction
  function automatic logic signed [15:0] c_offset(input coeff_t c);
    return c[31:16];
  endfunction
  function automatic logic signed [15:0] c_lo(input coeff_t c);
    return c[47:32];
  endfunction
  function automatic logic signed [15:0] c_hi(input coeff_t c);
    return c[63:48];
  endfunction

  // Offset then clamp; a lower bound above the upper bound ends at the upper one.
  function automatic logic signed [15:0] offset_clamp(input logic signed [39:0] x,
                                                      input coeff_t c);
    logic signed [40:0] v;
    v = 41'(x) + 41'(c_offset(c));
    if (v < 41'(c_lo(c))) v = 41'(c_lo(c));
    if (v > 41'(c_hi(c))) v = 41'(c_hi(c));
    return v[15:0];
  endfunction

  function automatic logic signed [31:0] sat40(input logic signed [39:0] x);
    logic signed [31:0] r;
    if (x > 40'(ACC_MAX)) r = ACC_MAX;
    else if (x < 40'(ACC_MIN)) r = ACC_MIN;
    else r = x[31:0];
    return r;
  endfunction

  // One reduction step of a live value into the accumulator.
  function automatic logic signed [31:0] reduce_step(input logic [2:0] mode,
                                                     input logic signed [31:0] acc,
                                                     input logic signed [15:0] v);
    logic signed [47:0] p;
    logic signed [39:0] s;
    logic signed [31:0] r;
    p = acc * v;
    s = 40'(acc) + 40'(v);
    unique case (mode)
      MODE_MIN:  r = (32'(v) < acc) ? 32'(v) : acc;
      MODE_MAX:  r = (32'(v) > acc) ? 32'(v) : acc;
      MODE_AVG,
      MODE_SUM:  r = sat40(s);
      MODE_PROD: r = sat40(p[47:8]);
      default:   r = '0;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/sensor_ensemble_combiner_top.sv
// Top level of the sensor ensemble combiner: configuration registers, child lanes,
// merging chain and outer stage. Depends on sec_pkg, sec_lane, sec_merge, sec_outer.
//
// Use: each input beat carries four signed Q8.8 child readings in in_tdata and their
// live flags in in_tuser. Each live reading is scaled, offset and clamped in its own
// lane, the lanes are merged by the reduction that cfg register 0 selects, and the
// result goes through the outer scale, offset and clamp. One output beat per input
// beat carries the combined value and the number of live children.
// Throughput is one beat per cycle while out_tready does not hold the pipeline.
// There are two lane stages, one merge stage per child (each holds one multiplier
// for the product), and three outer stages.
// The configuration port writes one register per cycle with cfg_we; write it only
// while no beat is in flight.
// Reset (rst_n low, synchronous) empties the pipeline and loads mode sum with unit
// coefficients. When out_tready is low with a result waiting, the whole pipeline
// holds and in_tready drops in the same cycle.
module sensor_ensemble_combiner_top
  import sec_pkg::*;
#(
  parameter int CHILD_COUNT = DEF_CHILD_COUNT
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [63:0]            in_tdata,  // reading_a, reading_b, reading_c, reading_d
  input  logic [3:0]             in_tuser,  // live_a, live_b, live_c, live_d
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [23:0]            out_tdata, // combined_value, live_count, zero pad
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int LAT = CHILD_COUNT + 5;

  logic [2:0]     mode_r;
  coeff_t         child_r [MAX_CHILDREN];
  coeff_t         outer_r;
  logic [LAT-1:0] valid_r;
  logic           en;

  logic signed [15:0] lane_val [MAX_CHILDREN];
  logic [MAX_CHILDREN-1:0] lane_live;
  logic signed [31:0] merge_acc;
  logic [2:0]         merge_cnt;
  logic signed [15:0] final_val;
  logic [2:0]         final_cnt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_RESET;
      outer_r <= COEFF_RESET;
      for (int i = 0; i < MAX_CHILDREN; i++) child_r[i] <= COEFF_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_MODE) mode_r <= cfg_wdata[2:0];
      else if (cfg_index >= CFG_CHILD_A && cfg_index <= CFG_CHILD_D)
        child_r[2'(cfg_index - CFG_CHILD_A)] <= cfg_wdata;
      else if (cfg_index == CFG_OUTER) outer_r <= cfg_wdata;
    end
  end

  assign en        = !valid_r[LAT-1] || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (en) begin
      valid_r <= {valid_r[LAT-2:0], in_tvalid};
    end
  end

  for (genvar i = 0; i < MAX_CHILDREN; i++) begin : g_lane
    if (i < CHILD_COUNT) begin : g_used
      sec_lane u_lane (
        .clk     (clk),
        .en      (en),
        .reading (in_tdata[16*i +: 16]),
        .live    (in_tuser[i]),
        .coeff   (child_r[i]),
        .value   (lane_val[i]),
        .live_o  (lane_live[i])
      );
    end else begin : g_unused
      assign lane_val[i]  = '0;
      assign lane_live[i] = 1'b0;
    end
  end

  sec_merge #(.CHILD_COUNT(CHILD_COUNT)) u_merge (
    .clk   (clk),
    .en    (en),
    .mode  (mode_r),
    .outer (outer_r),
    .vals  (lane_val),
    .lives (lane_live),
    .acc   (merge_acc),
    .count (merge_cnt)
  );

  sec_outer u_outer (
    .clk     (clk),
    .en      (en),
    .mode    (mode_r),
    .outer   (outer_r),
    .acc     (merge_acc),
    .count   (merge_cnt),
    .value   (final_val),
    .count_o (final_cnt)
  );

  assign out_tvalid = valid_r[LAT-1];
  assign out_tdata  = {5'd0, final_cnt, final_val};

endmodule

FILE: rtl/sec_lane.sv
// One child lane: scale, then offset and clamp, in two pipeline stages.
// Depends on sec_pkg.
module sec_lane
  import sec_pkg::*;
(
  input  logic               clk,
  input  logic               en,
  input  logic signed [15:0] reading,
  input  logic               live,
  input  coeff_t             coeff,
  output logic signed [15:0] value,
  output logic               live_o
);

  logic signed [31:0] prod_r;
  logic               live1_r;
  logic signed [15:0] value_r;
  logic               live2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r  <= reading * c_scale(coeff);
      live1_r <= live;
      // Arithmetic shift gives the floor of the division by 256.
      value_r <= offset_clamp(40'(prod_r >>> 8), coeff);
      live2_r <= live1_r;
    end
  end

  assign value  = value_r;
  assign live_o = live2_r;

endmodule

FILE: rtl/sec_merge.sv
// Merging chain: one registered reduction step per child lane.
// Depends on sec_pkg.
module sec_merge
  import sec_pkg::*;
#(
  parameter int CHILD_COUNT = DEF_CHILD_COUNT
) (
  input  logic               clk,
  input  logic               en,
  input  logic [2:0]         mode,
  input  coeff_t             outer,
  input  logic signed [15:0] vals   [MAX_CHILDREN],
  input  logic [MAX_CHILDREN-1:0] lives,
  output logic signed [31:0] acc,
  output logic [2:0]         count
);

  logic signed [31:0] acc_r  [CHILD_COUNT];
  logic signed [15:0] vals_r [CHILD_COUNT][MAX_CHILDREN];
  logic [MAX_CHILDREN-1:0] live_r [CHILD_COUNT];
  logic [2:0]         cnt_r  [CHILD_COUNT];

  logic signed [31:0] acc_init;
  logic [2:0]         cnt_init;

  always_comb begin
    unique case (mode)
      MODE_MIN:  acc_init = 32'(c_hi(outer));
      MODE_MAX:  acc_init = 32'(c_lo(outer));
      MODE_PROD: acc_init = ACC_ONE;
      default:   acc_init = '0;
    endcase
    cnt_init = '0;
    for (int i = 0; i < CHILD_COUNT; i++) begin
      cnt_init = cnt_init + 3'(lives[i]);
    end
  end

  for (genvar k = 0; k < CHILD_COUNT; k++) begin : g_step
    logic signed [31:0] acc_in;
    logic signed [15:0] v_in [MAX_CHILDREN];
    logic [MAX_CHILDREN-1:0] l_in;
    logic [2:0] c_in;
    if (k == 0) begin : g_first
      assign acc_in = acc_init;
      assign v_in   = vals;
      assign l_in   = lives;
      assign c_in   = cnt_init;
    end else begin : g_next
      assign acc_in = acc_r[k-1];
      assign v_in   = vals_r[k-1];
      assign l_in   = live_r[k-1];
      assign c_in   = cnt_r[k-1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        acc_r[k]  <= l_in[k] ? reduce_step(mode, acc_in, v_in[k]) : acc_in;
        vals_r[k] <= v_in;
        live_r[k] <= l_in;
        cnt_r[k]  <= c_in;
      end
    end
  end

  assign acc   = acc_r[CHILD_COUNT-1];
  assign count = cnt_r[CHILD_COUNT-1];

endmodule

FILE: rtl/sec_outer.sv
// Final stages: raw result (average division), then outer scale, offset and clamp.
// Depends on sec_pkg.
module sec_outer
  import sec_pkg::*;
(
  input  logic               clk,
  input  logic               en,
  input  logic [2:0]         mode,
  input  coeff_t             outer,
  input  logic signed [31:0] acc,
  input  logic [2:0]         count,
  output logic signed [15:0] value,
  output logic [2:0]         count_o
);

  localparam logic [17:0] RECIP3 = 18'd174763; // ceil(2^19 / 3)

  logic signed [31:0] raw_r;
  logic signed [47:0] mult_r;
  logic signed [15:0] value_r;
  logic [2:0]         cnt1_r, cnt2_r, cnt3_r;

  logic [17:0]        mag;
  logic [17:0]        quo;
  logic [35:0]        q3;
  logic signed [31:0] raw_nxt;

  // The average's sum never exceeds 18 bits, so the division works on its magnitude.
  always_comb begin
    mag = acc[31] ? 18'(-acc) : acc[17:0];
    q3  = mag * RECIP3;
    unique case (count)
      3'd2:    quo = mag >> 1;
      3'd3:    quo = 18'(q3[35:19]);
      3'd4:    quo = mag >> 2;
      default: quo = mag;
    endcase
    if (count == '0 || mode > MODE_PROD) raw_nxt = '0;
    else if (mode == MODE_AVG) raw_nxt = acc[31] ? -32'(quo) : 32'(quo);
    else raw_nxt = acc;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      raw_r   <= raw_nxt;
      cnt1_r  <= count;
      mult_r  <= raw_r * c_scale(outer);
      cnt2_r  <= cnt1_r;
      value_r <= offset_clamp(mult_r[47:8], outer);
      cnt3_r  <= cnt2_r;
    end
  end

  assign value   = value_r;
  assign count_o = cnt3_r;

endmodule

FILE: sim/sensor_ensemble_combiner_top_tb.sv
// Testbench for sensor_ensemble_combiner_top: directed table, mode sweep, clamp
// cases, then random beats, each output beat checked against a predictor of the
// Q8.8 reduction datapath. Depends on sec_pkg and the RTL in rtl/.
`timescale 1ns / 1ps

module sensor_ensemble_combiner_top_tb;
  import sec_pkg::*;

  typedef struct packed {
    logic signed [15:0] value;
    logic [2:0]         count;
  } combined_t;

  typedef struct {
    logic [63:0] readings;
    logic [3:0]  live;
    bit          has_expected;
    combined_t   expected;
  } stim_row_t;

  localparam int CHILD_COUNT_LAT = DEF_CHILD_COUNT + 5;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [63:0] in_tdata = '0;
  logic [3:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Local copy of the register file for the predictor.
  logic [2:0] mode_reg;
  coeff_t child_coeff[4];
  coeff_t outer_coeff;

  combined_t pending_results[$];
  int mismatches = 0;
  int beats_seen = 0;
  bit quiet_sender = 1'b0;  // long stretch without idling
  bit quiet_receiver = 1'b0;
  int hold_cycles = 0;      // receiver hold-off counted in its own process

  sensor_ensemble_combiner_top dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic longint div256_floor(input longint x);
    return (x - (((x % 256) + 256) % 256)) / 256;
  endfunction

  function automatic longint clip32(input longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint scale_offset_clamp(input longint x, input coeff_t c);
    longint v;
    longint lo;
    longint hi;
    v = div256_floor(x * longint'($signed(c[15:0]))) + longint'($signed(c[31:16]));
    lo = longint'($signed(c[47:32]));
    hi = longint'($signed(c[63:48]));
    if (v < lo) v = lo;
    if (v > hi) v = hi;
    return v;
  endfunction

  function automatic combined_t combine_readings(input logic [63:0] rd, input logic [3:0] lv);
    longint acc;
    longint v;
    longint raw;
    int n;
    combined_t r;
    n = 0;
    case (mode_reg)
      MODE_MIN:  acc = longint'($signed(outer_coeff[63:48]));
      MODE_MAX:  acc = longint'($signed(outer_coeff[47:32]));
      MODE_PROD: acc = 256;
      default:   acc = 0;
    endcase
    for (int i = 0; i < 4; i++) begin
      if (lv[i]) begin
        v = scale_offset_clamp(longint'($signed(rd[16*i +: 16])), child_coeff[i]);
        case (mode_reg)
          MODE_MIN: if (v < acc) acc = v;
          MODE_MAX: if (v > acc) acc = v;
          MODE_AVG, MODE_SUM: acc = clip32(acc + v);
          MODE_PROD: acc = clip32(div256_floor(acc * v));
          default: acc = 0;
        endcase
        n++;
      end
    end
    if (n == 0 || mode_reg > MODE_PROD) raw = 0;
    else if (mode_reg == MODE_AVG) raw = acc / n;
    else raw = acc;
    r.value = 16'(scale_offset_clamp(raw, outer_coeff));
    r.count = 3'(n);
    return r;
  endfunction

  // One write per call; the enable drops before the next write.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_MODE) mode_reg = val[2:0];
    else if (idx >= CFG_CHILD_A && idx <= CFG_CHILD_D)
      child_coeff[2'(idx - CFG_CHILD_A)] = val;
    else if (idx == CFG_OUTER) outer_coeff = val;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (CHILD_COUNT_LAT + 4) @(posedge clk);
  endtask

  function automatic coeff_t random_coeff();
    logic [15:0] lo;
    logic [15:0] hi;
    coeff_t c;
    c = {$urandom, $urandom};
    // Mostly ordered clamps, sometimes inverted ones.
    if ($urandom_range(0, 3) != 0) begin
      lo = 16'($signed(-($urandom_range(0, 32768))));
      hi = 16'($urandom_range(0, 32767));
      c[47:32] = lo;
      c[63:48] = hi;
    end
    if ($urandom_range(0, 2) == 0) c[15:0] = 16'($urandom_range(0, 1024)) - 16'd512;
    return c;
  endfunction

  // Offers one beat; the predictor runs on acceptance. The valid stays high after
  // acceptance so that the next beat can follow without a gap.
  task automatic send_beat(input logic [63:0] rd, input logic [3:0] lv,
                           input bit has_exp, input combined_t exp_r);
    combined_t pred;
    while (!quiet_sender && $urandom_range(0, 99) < 35) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= rd;
    in_tuser <= lv;
    do @(posedge clk); while (!in_tready);
    pred = combine_readings(rd, lv);
    if (has_exp && pred != exp_r) begin
      mismatches++;
      if (mismatches <= 10)
        $display("table row disagrees with predictor: row %h got %h", exp_r, pred);
    end
    pending_results.push_back(pred);
  endtask

  // Receiver with random stalls and an optional long hold-off.
  always @(posedge clk) begin
    combined_t got;
    combined_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = {out_tdata[15:0], out_tdata[18:16]};
        beats_seen++;
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected output beat %h", out_tdata);
        end else begin
          want = pending_results.pop_front();
          if (got.value !== want.value || got.count !== want.count
              || out_tdata[23:19] !== '0) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected value %h count %0d, got value %h count %0d",
                       want.value, want.count, got.value, got.count);
          end
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= quiet_receiver || ($urandom_range(0, 99) >= 35);
      end
    end
  end

  stim_row_t stim_table[$];

  function automatic stim_row_t row(input logic [63:0] rd, input logic [3:0] lv,
                                    input bit he, input logic [15:0] v, input int n);
    stim_row_t r;
    r.readings = rd;
    r.live = lv;
    r.has_expected = he;
    r.expected.value = v;
    r.expected.count = 3'(n);
    return r;
  endfunction

  initial begin
    logic [63:0] rd;
    logic [3:0] lv;
    mode_reg = MODE_RESET;
    for (int i = 0; i < 4; i++) child_coeff[i] = COEFF_RESET;
    outer_coeff = COEFF_RESET;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // After reset: sum with unit coefficients and full clamps.
    stim_table.push_back(row(64'h0, 4'h0, 1, 16'h0000, 0));
    stim_table.push_back(row(64'h0001_0001_0001_0100, 4'hF, 1, 16'h0103, 4));
    stim_table.push_back(row(64'h7FFF_7FFF_7FFF_7FFF, 4'hF, 1, 16'h7FFF, 4));
    stim_table.push_back(row(64'h8000_8000_8000_8000, 4'hF, 1, 16'h8000, 4));
    stim_table.push_back(row(64'h8000_7FFF_1234_FFFF, 4'h5, 0, 0, 0));
    stim_table.push_back(row(64'hFFFF_FFFF_FFFF_FFFF, 4'hA, 1, 16'hFFFE, 2));
    foreach (stim_table[i])
      send_beat(stim_table[i].readings, stim_table[i].live,
                stim_table[i].has_expected, stim_table[i].expected);
    wait_drained();

    // Every mode, including unused codes, on a few extreme beats.
    for (int m = 0; m < 8; m++) begin
      write_reg(CFG_MODE, 64'(m));
      send_beat(64'h7FFF_8000_0100_FF00, 4'hF, 0, '0);
      send_beat(64'h7FFF_7FFF_7FFF_7FFF, 4'hF, 0, '0);
      send_beat(64'h1234_5678_9ABC_DEF0, 4'h0, 0, '0);
      wait_drained();
    end
    // Inverted clamp on a child, extreme scale on a child and on the outer stage.
    write_reg(CFG_MODE, 64'(MODE_PROD));
    write_reg(CFG_CHILD_A, 64'h8000_7FFF_7FFF_7FFF);
    write_reg(CFG_OUTER, 64'h7FFF_8000_8000_8000);
    send_beat(64'h7FFF_7FFF_7FFF_7FFF, 4'hF, 0, '0);
    send_beat(64'h8000_8000_8000_8000, 4'hF, 0, '0);
    wait_drained();

    // Random phases, each with new settings; one phase without idling.
    for (int ph = 0; ph < 10; ph++) begin
      write_reg(CFG_MODE, 64'($urandom_range(0, 7)));
      for (int i = 0; i < 4; i++)
        write_reg(CFG_INDEX_W'(CFG_CHILD_A + i),
                  ($urandom_range(0, 4) == 0) ? COEFF_RESET : random_coeff());
      write_reg(CFG_OUTER, ($urandom_range(0, 2) == 0) ? COEFF_RESET : random_coeff());
      if (ph == 7) write_reg(3'd7, {$urandom, $urandom});
      quiet_sender = (ph == 3);
      quiet_receiver = (ph == 3);
      if (ph == 5) hold_cycles = 200;
      for (int k = 0; k < 120; k++) begin
        rd = {$urandom, $urandom};
        if ($urandom_range(0, 5) == 0) rd[16*$urandom_range(0, 3) +: 16] = 16'h8000;
        if ($urandom_range(0, 5) == 0) rd[16*$urandom_range(0, 3) +: 16] = 16'h7FFF;
        if ($urandom_range(0, 3) == 0) rd = rd & 64'h03FF_03FF_03FF_03FF;
        lv = 4'($urandom);
        send_beat(rd, lv, 0, '0);
        // The sender waits here until every result is back.
        if (ph == 2 && k == 60) begin
          in_tvalid <= 1'b0;
          while (pending_results.size() != 0) @(posedge clk);
        end
      end
      wait_drained();
    end
    quiet_sender = 1'b0;
    quiet_receiver = 1'b0;

    if (mismatches == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
